// ===== src/mpvs_pkg.sv =====
// shared types and constants for the multilevel priority value scheduler
// no dependencies; used by the top level
package mpvs_pkg;

	// default sizes
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int LEVEL_COUNT      = 4;
	localparam int TASK_ID_BITS_DEF = 8;

	// register reset values
	localparam logic [31:0] BASE_VALUES_RST = 32'd3365299250;
	localparam logic [31:0] DELTA_TABLE_RST = 32'd17107481;

	// register indexes
	localparam logic [1:0] CFG_BASE_VALUES = 2'd0;
	localparam logic [1:0] CFG_DELTA_TABLE = 2'd1;

	// action codes
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_PICK   = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] task_id;
		logic [1:0] level;
	} req_word_t;

	typedef struct packed {
		logic       selected_valid;
		logic [7:0] selected_task;
		logic [7:0] selected_value;
		logic [1:0] status;
	} rsp_word_t;

endpackage

// ===== src/multilevel_priority_value_scheduler.sv =====
// multilevel priority value scheduler: four task queues in one shared entry memory
// depends on mpvs_pkg
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one command word: add a task
//   to a level, remove a task from a level, or pick the next task. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one result word per command.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes base_values
//   (index 0) or delta_table (index 1); cfg_ready is always high, write only when idle.
//   All queue work runs through one entry memory with one read and one write port
//   under a small sequencer; req_stall is high while a command is in progress.
//   Steps per command: add writes the new entry at the front of its level; pick
//   reads and checks each nonempty level, plus a second read after a rotation, then
//   one select step and, if a task is found, four decrement steps; remove reads from
//   the front to the matching id, then shifts each later entry up by a read and write.
//   The result goes to an output register; the next command is taken while it
//   waits. If rsp_stall holds a result and another finishes, the sequencer waits
//   in its done state until the register frees.
//   Reset clears queue heads and counts, the last selected and last run marks,
//   and restores both registers; the entry memory itself is not cleared.
module multilevel_priority_value_scheduler #(
	parameter int QUEUE_DEPTH  = mpvs_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = mpvs_pkg::TASK_ID_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mpvs_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mpvs_pkg::rsp_word_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int LC = mpvs_pkg::LEVEL_COUNT;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(LC * QUEUE_DEPTH);
	localparam int MD = LC * QUEUE_DEPTH;

	typedef struct packed {
		logic [TASK_ID_BITS-1:0] id;
		logic [7:0]              val;
	} entry_t;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_ADD    = 13'b0000000000010,
		ST_RM_RD  = 13'b0000000000100,
		ST_RM_CMP = 13'b0000000001000,
		ST_SH_RD  = 13'b0000000010000,
		ST_SH_WR  = 13'b0000000100000,
		ST_PK_RD  = 13'b0000001000000,
		ST_PK_CHK = 13'b0000010000000,
		ST_PK_RD2 = 13'b0000100000000,
		ST_PK_CAP = 13'b0001000000000,
		ST_PK_SEL = 13'b0010000000000,
		ST_PK_DEC = 13'b0100000000000,
		ST_DONE   = 13'b1000000000000
	} state_t;

	// position within a level's ring, head plus offset
	function automatic logic [PW-1:0] wrap(input logic [PW-1:0] head, input logic [CW-1:0] k);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(k);
		if (sum >= (CW+1)'(QUEUE_DEPTH))
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		return PW'(sum);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [1:0] lvl, input logic [PW-1:0] pos);
		return AW'(AW'(lvl) * AW'(QUEUE_DEPTH)) + AW'(pos);
	endfunction

	function automatic logic [7:0] sat_dec(input logic [7:0] v, input logic [7:0] d);
		return (d >= v) ? 8'd0 : v - d;
	endfunction

	function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic [7:0] d);
		return ((8'd255 - v) <= d) ? 8'd255 : v + d;
	endfunction

	state_t                  st_q;
	logic [TASK_ID_BITS-1:0] id_q;
	logic [1:0]              lvl_q;
	logic [CW-1:0]           k_q;
	logic [1:0]              li_q;
	logic [1:0]              best_q;
	logic [31:0]             base_q;
	logic [31:0]             delta_q;
	logic [PW-1:0]           heads_q [LC];
	logic [CW-1:0]           counts_q [LC];
	logic [LC-1:0]           has_q;
	logic [TASK_ID_BITS-1:0] cid_q [LC];
	logic [7:0]              cval_q [LC];
	logic [LC-1:0]           selv_q;
	logic [TASK_ID_BITS-1:0] selid_q [LC];
	logic                    ranv_q;
	logic [TASK_ID_BITS-1:0] ranid_q;
	mpvs_pkg::rsp_word_t     pend_q;
	mpvs_pkg::rsp_word_t     rsp_q;
	logic                    rsp_vld_q;

	entry_t                  mem_q [MD];
	entry_t                  rd_q;

	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	entry_t                  wr_data;

	logic [CW-1:0]           cur_n;
	logic [PW-1:0]           cur_head;
	logic [PW-1:0]           li_head;
	logic [CW-1:0]           li_cnt;
	logic [CW-1:0]           k_nx;
	logic                    rot;
	logic [7:0]              rot_val;
	logic                    found;
	logic [1:0]              bi;
	logic [15:0]             best_id_ext;

	assign req_stall = (st_q != ST_IDLE);
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	assign cur_n    = counts_q[lvl_q];
	assign cur_head = heads_q[lvl_q];
	assign li_head  = heads_q[li_q];
	assign li_cnt   = counts_q[li_q];
	assign k_nx     = CW'(k_q + 1'b1);

	// front matches the level's last selection, so it rotates to the back
	assign rot     = selv_q[li_q] && (rd_q.id == selid_q[li_q]);
	assign rot_val = (ranv_q && (rd_q.id == ranid_q))
		? sat_inc(rd_q.val, delta_q[{~li_q, 3'b000} +: 8]) : rd_q.val;

	// smallest candidate wins, ties to the lower level
	always_comb begin
		found = 1'b0;
		bi    = 2'd0;
		for (int i = 0; i < LC; i++) begin
			if (has_q[i] && (!found || (cval_q[i] < cval_q[bi]))) begin
				found = 1'b1;
				bi    = 2'(i);
			end
		end
	end

	assign best_id_ext = 16'(cid_q[bi]);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (st_q)
			ST_ADD: begin
				wr_en   = (cur_n != CW'(QUEUE_DEPTH));
				wr_addr = addr_of(lvl_q, (cur_head == '0) ? PW'(QUEUE_DEPTH - 1) : cur_head - 1'b1);
				wr_data = '{id: id_q, val: base_q[{lvl_q, 3'b000} +: 8]};
			end
			ST_RM_RD: begin
				rd_en   = 1'b1;
				rd_addr = addr_of(lvl_q, wrap(cur_head, k_q));
			end
			ST_SH_RD: begin
				rd_en   = 1'b1;
				rd_addr = addr_of(lvl_q, wrap(cur_head, k_nx));
			end
			ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = addr_of(lvl_q, wrap(cur_head, k_q));
				wr_data = rd_q;
			end
			ST_PK_RD, ST_PK_RD2: begin
				rd_en   = (li_cnt != '0);
				rd_addr = addr_of(li_q, li_head);
			end
			ST_PK_CHK: begin
				wr_en   = rot;
				wr_addr = addr_of(li_q, wrap(li_head, li_cnt));
				wr_data = '{id: rd_q.id, val: rot_val};
			end
			ST_PK_DEC: begin
				wr_en   = has_q[li_q] && (li_q != best_q);
				wr_addr = addr_of(li_q, li_head);
				wr_data = '{id: cid_q[li_q],
					val: sat_dec(cval_q[li_q], delta_q[{li_q, 3'b000} +: 8])};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	// sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			id_q      <= '0;
			lvl_q     <= '0;
			k_q       <= '0;
			li_q      <= '0;
			best_q    <= '0;
			base_q    <= mpvs_pkg::BASE_VALUES_RST;
			delta_q   <= mpvs_pkg::DELTA_TABLE_RST;
			has_q     <= '0;
			selv_q    <= '0;
			ranv_q    <= 1'b0;
			ranid_q   <= '0;
			pend_q    <= '0;
			rsp_q     <= '0;
			rsp_vld_q <= 1'b0;
			for (int i = 0; i < LC; i++) begin
				heads_q[i]  <= '0;
				counts_q[i] <= '0;
				selid_q[i]  <= '0;
				cid_q[i]    <= '0;
				cval_q[i]   <= '0;
			end
		end else begin
			// configuration writes
			if (cfg_valid) begin
				if (cfg_index == mpvs_pkg::CFG_BASE_VALUES)
					base_q <= cfg_data;
				else if (cfg_index == mpvs_pkg::CFG_DELTA_TABLE)
					delta_q <= cfg_data;
			end

			// result word taken, unless a new one replaces it
			if (rsp_vld_q && !rsp_stall && (st_q != ST_DONE))
				rsp_vld_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						id_q   <= TASK_ID_BITS'(req.task_id);
						lvl_q  <= req.level;
						k_q    <= '0;
						li_q   <= '0;
						case (req.action)
							mpvs_pkg::ACT_ADD: begin
								pend_q <= '0;
								st_q   <= ST_ADD;
							end
							mpvs_pkg::ACT_REMOVE: begin
								if (counts_q[req.level] == '0) begin
									pend_q <= '{selected_valid: 1'b0, selected_task: 8'd0,
										selected_value: 8'd0,
										status: mpvs_pkg::STATUS_MISSING};
									st_q   <= ST_DONE;
								end else begin
									pend_q <= '0;
									st_q   <= ST_RM_RD;
								end
							end
							mpvs_pkg::ACT_PICK: begin
								pend_q <= '0;
								st_q   <= ST_PK_RD;
							end
							default: begin
								pend_q <= '0;
								st_q   <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (cur_n == CW'(QUEUE_DEPTH)) begin
						pend_q.status <= mpvs_pkg::STATUS_FULL;
					end else begin
						heads_q[lvl_q]  <= (cur_head == '0) ? PW'(QUEUE_DEPTH - 1)
							: cur_head - 1'b1;
						counts_q[lvl_q] <= cur_n + 1'b1;
					end
					st_q <= ST_DONE;
				end
				ST_RM_RD: st_q <= ST_RM_CMP;
				// walk from the front looking for the id
				ST_RM_CMP: begin
					if (rd_q.id == id_q) begin
						if ((CW+1)'(k_nx) < (CW+1)'(cur_n)) begin
							st_q <= ST_SH_RD;
						end else begin
							counts_q[lvl_q] <= cur_n - 1'b1;
							st_q            <= ST_DONE;
						end
					end else if (k_nx == cur_n) begin
						pend_q.status <= mpvs_pkg::STATUS_MISSING;
						st_q          <= ST_DONE;
					end else begin
						k_q  <= k_nx;
						st_q <= ST_RM_RD;
					end
				end
				ST_SH_RD: st_q <= ST_SH_WR;
				// close the gap one entry at a time
				ST_SH_WR: begin
					k_q <= k_nx;
					if (((CW+1)'(k_nx) + 1'b1) < (CW+1)'(cur_n)) begin
						st_q <= ST_SH_RD;
					end else begin
						counts_q[lvl_q] <= cur_n - 1'b1;
						st_q            <= ST_DONE;
					end
				end
				ST_PK_RD: begin
					if (li_cnt == '0) begin
						has_q[li_q] <= 1'b0;
						if (li_q == 2'd3) begin
							st_q <= ST_PK_SEL;
						end else begin
							li_q <= li_q + 1'b1;
						end
					end else begin
						st_q <= ST_PK_CHK;
					end
				end
				ST_PK_CHK, ST_PK_CAP: begin
					if ((st_q == ST_PK_CHK) && rot) begin
						heads_q[li_q] <= (li_head == PW'(QUEUE_DEPTH - 1)) ? '0
							: li_head + 1'b1;
						st_q <= ST_PK_RD2;
					end else begin
						has_q[li_q]   <= 1'b1;
						cid_q[li_q]   <= rd_q.id;
						cval_q[li_q]  <= rd_q.val;
						selv_q[li_q]  <= 1'b1;
						selid_q[li_q] <= rd_q.id;
						if (li_q == 2'd3) begin
							st_q <= ST_PK_SEL;
						end else begin
							li_q <= li_q + 1'b1;
							st_q <= ST_PK_RD;
						end
					end
				end
				ST_PK_RD2: st_q <= ST_PK_CAP;
				ST_PK_SEL: begin
					if (found) begin
						best_q  <= bi;
						ranv_q  <= 1'b1;
						ranid_q <= cid_q[bi];
						pend_q  <= '{selected_valid: 1'b1, selected_task: best_id_ext[7:0],
							selected_value: cval_q[bi], status: mpvs_pkg::STATUS_OK};
						li_q    <= '0;
						st_q    <= ST_PK_DEC;
					end else begin
						st_q <= ST_DONE;
					end
				end
				// losers age toward zero
				ST_PK_DEC: begin
					if (li_q == 2'd3) begin
						st_q <= ST_DONE;
					end else begin
						li_q <= li_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!rsp_vld_q || !rsp_stall) begin
						rsp_q     <= pend_q;
						rsp_vld_q <= 1'b1;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
